/* rtl/phsl_pkg.sv */
// Shared types and constants for the packed HSL to RGB converter.
// Used by phsl_decode, phsl_channel and packed_hsl_to_rgb; depends on nothing.
package phsl_pkg;

  // Unsigned fixed point with 24 fraction bits and one integer bit.
  localparam int FRAC_BITS = 24;
  localparam int FX_W      = FRAC_BITS + 1;

  localparam logic [FX_W-1:0] FX_ONE        = 25'd16777216;
  localparam logic [FX_W-1:0] FX_HALF       = 25'd8388608;
  localparam logic [FX_W-1:0] FX_THIRD      = 25'd5592405;
  localparam logic [FX_W-1:0] FX_TWO_THIRDS = 25'd11184811;

  // Segment of the hue ramp that a channel falls in.
  typedef logic [1:0] region_t;
  localparam region_t REGION_RISE = 2'd0;
  localparam region_t REGION_HIGH = 2'd1;
  localparam region_t REGION_FALL = 2'd2;
  localparam region_t REGION_LOW  = 2'd3;

  // Decoded color after the first pipeline stage.
  typedef struct packed {
    logic [FX_W-1:0] p;
    logic [FX_W-1:0] q;
    logic [FX_W-1:0] t_red;
    logic [FX_W-1:0] t_green;
    logic [FX_W-1:0] t_blue;
    logic [7:0]      alpha;
  } stage_t;

endpackage

/* rtl/phsl_decode.sv */
// First pipeline stage: unpacks hue, saturation and lightness and forms P, Q
// and the three wrapped hue positions. Depends on phsl_pkg.
module phsl_decode (
  input  logic                 clk,
  input  logic [15:0]          packed_hsl,
  output phsl_pkg::stage_t     stage
);

  logic [5:0]                  h;
  logic [2:0]                  s;
  logic [6:0]                  l;
  logic [3:0]                  s_odd;
  logic [10:0]                 ls_raw;
  logic [phsl_pkg::FX_W-1:0]   hue;
  logic [phsl_pkg::FX_W-1:0]   sat;
  logic [phsl_pkg::FX_W-1:0]   lum;
  logic [phsl_pkg::FX_W-1:0]   ls;
  logic [phsl_pkg::FX_W-1:0]   q;
  logic [phsl_pkg::FX_W-1:0]   red_sum;
  phsl_pkg::stage_t            stage_next;

  assign h      = packed_hsl[15:10];
  assign s      = packed_hsl[9:7];
  assign l      = packed_hsl[6:0];
  assign s_odd  = {s, 1'b1};
  assign ls_raw = 11'(l) * 11'(s_odd);

  assign hue = phsl_pkg::FX_W'({h, 1'b1}) << 17;
  assign sat = phsl_pkg::FX_W'(s_odd) << 20;
  assign lum = phsl_pkg::FX_W'(l) << 17;
  assign ls  = phsl_pkg::FX_W'(ls_raw) << 13;

  // Lightness below one half scales up; above it moves toward white.
  assign q = l[6] ? (lum + sat - ls) : (lum + ls);

  assign red_sum = hue + phsl_pkg::FX_THIRD;

  always_comb begin
    stage_next.q       = q;
    stage_next.p       = (lum << 1) - q;
    stage_next.t_red   = (red_sum > phsl_pkg::FX_ONE) ? (red_sum - phsl_pkg::FX_ONE) : red_sum;
    stage_next.t_green = hue;
    stage_next.t_blue  = (hue < phsl_pkg::FX_THIRD) ?
                         (hue + (phsl_pkg::FX_ONE - phsl_pkg::FX_THIRD)) :
                         (hue - phsl_pkg::FX_THIRD);
    // l*255/127 is 2l, plus one only at full lightness.
    stage_next.alpha   = {l, 1'b0} + {7'd0, (l == 7'h7f)};
  end

  always_ff @(posedge clk) begin
    stage <= stage_next;
  end

endmodule

/* rtl/phsl_channel.sv */
// Three pipeline stages for one color channel: ramp segment select, ramp
// multiply, then blend and scale to a byte. Depends on phsl_pkg.
module phsl_channel (
  input  logic                        clk,
  input  logic [phsl_pkg::FX_W-1:0]   t,
  input  logic [phsl_pkg::FX_W-1:0]   p,
  input  logic [phsl_pkg::FX_W-1:0]   q,
  output logic [7:0]                  value
);

  // Segment select.
  logic [27:0]                 six_t;
  logic [26:0]                 three_t;
  logic [phsl_pkg::FX_W-1:0]   fall_span;
  logic [27:0]                 six_fall;
  phsl_pkg::region_t           region_next;
  logic [phsl_pkg::FX_W-1:0]   m_next;

  phsl_pkg::region_t           region_a;
  logic [phsl_pkg::FX_W-1:0]   m_a;
  logic [phsl_pkg::FX_W-1:0]   d_a;
  logic [phsl_pkg::FX_W-1:0]   p_a;
  logic [phsl_pkg::FX_W-1:0]   q_a;

  // Multiply.
  logic [49:0]                 prod;
  phsl_pkg::region_t           region_b;
  logic [25:0]                 ramp_b;
  logic [phsl_pkg::FX_W-1:0]   p_b;
  logic [phsl_pkg::FX_W-1:0]   q_b;

  // Blend and scale.
  logic [26:0]                 v;
  logic [34:0]                 scaled;
  logic [10:0]                 level;
  logic [7:0]                  value_next;

  assign six_t     = ({3'b000, t} << 2) + ({3'b000, t} << 1);
  assign three_t   = {2'b00, t} + {1'b0, t, 1'b0};
  assign fall_span = phsl_pkg::FX_TWO_THIRDS - t;
  assign six_fall  = ({3'b000, fall_span} << 2) + ({3'b000, fall_span} << 1);

  always_comb begin
    if (six_t < {3'b000, phsl_pkg::FX_ONE}) begin
      region_next = phsl_pkg::REGION_RISE;
    end else if (t < phsl_pkg::FX_HALF) begin
      region_next = phsl_pkg::REGION_HIGH;
    end else if (three_t < {1'b0, phsl_pkg::FX_ONE, 1'b0}) begin
      region_next = phsl_pkg::REGION_FALL;
    end else begin
      region_next = phsl_pkg::REGION_LOW;
    end
    // The multiplicand only matters on the two ramps, where it fits 25 bits.
    m_next = (region_next == phsl_pkg::REGION_RISE) ? six_t[24:0] : six_fall[24:0];
  end

  always_ff @(posedge clk) begin
    region_a <= region_next;
    m_a      <= m_next;
    d_a      <= q - p;
    p_a      <= p;
    q_a      <= q;
  end

  assign prod = 50'(d_a) * 50'(m_a);

  always_ff @(posedge clk) begin
    region_b <= region_a;
    ramp_b   <= prod[49:24];
    p_b      <= p_a;
    q_b      <= q_a;
  end

  always_comb begin
    case (region_b)
      phsl_pkg::REGION_RISE: v = {2'b00, p_b} + {1'b0, ramp_b};
      phsl_pkg::REGION_FALL: v = {2'b00, p_b} + {1'b0, ramp_b};
      phsl_pkg::REGION_HIGH: v = {2'b00, q_b};
      default:               v = {2'b00, p_b};
    endcase
    scaled     = {v, 8'd0} - {8'd0, v};
    level      = scaled[34:24];
    value_next = (level > 11'd255) ? 8'hff : level[7:0];
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

/* rtl/packed_hsl_to_rgb.sv */
// Packed HSL to RGB converter, top level.
// Depends on phsl_pkg, phsl_decode and phsl_channel.
//
// Takes one packed 16-bit HSL color per clock and returns red, green, blue and
// a lightness byte for each start beat, marked by a one-cycle done strobe.
// busy is always low: the pipeline is fully pipelined, one beat per clock,
// through its four register stages (decode, segment select, 25x25 ramp
// multiply, blend and scale). Results cannot be held off, so the receiver
// must take each beat in the cycle that done is high.
module packed_hsl_to_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] packed_hsl,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  light_alpha
);

  phsl_pkg::stage_t stage;
  logic             valid_1;
  logic             valid_2;
  logic             valid_3;
  logic [7:0]       alpha_2;
  logic [7:0]       alpha_3;

  assign busy = 1'b0;

  phsl_decode u_decode (
    .clk        (clk),
    .packed_hsl (packed_hsl),
    .stage      (stage)
  );

  phsl_channel u_red (
    .clk   (clk),
    .t     (stage.t_red),
    .p     (stage.p),
    .q     (stage.q),
    .value (red)
  );

  phsl_channel u_green (
    .clk   (clk),
    .t     (stage.t_green),
    .p     (stage.p),
    .q     (stage.q),
    .value (green)
  );

  phsl_channel u_blue (
    .clk   (clk),
    .t     (stage.t_blue),
    .p     (stage.p),
    .q     (stage.q),
    .value (blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_1 <= 1'b0;
      valid_2 <= 1'b0;
      valid_3 <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_1 <= start && !busy;
      valid_2 <= valid_1;
      valid_3 <= valid_2;
      done    <= valid_3;
    end
  end

  // The lightness byte rides alongside the channel pipelines.
  always_ff @(posedge clk) begin
    alpha_2     <= stage.alpha;
    alpha_3     <= alpha_2;
    light_alpha <= alpha_3;
  end

endmodule

/* bench/phsl_checker.sv */
// Checker for packed_hsl_to_rgb: predicts each color from the accepted input beats
// and compares every done beat with the oldest prediction. Depends on phsl_pkg.
`timescale 1ns / 1ps

module phsl_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] packed_hsl,
  input  logic        done,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  light_alpha,
  output int          fail_count,
  output int          pending,
  output int          results_checked
);

  localparam longint ONE_FX        = longint'(phsl_pkg::FX_ONE);
  localparam longint THIRD_FX      = longint'(phsl_pkg::FX_THIRD);
  localparam longint TWO_THIRDS_FX = longint'(phsl_pkg::FX_TWO_THIRDS);
  localparam int     MAX_REPORTS   = 40;

  typedef struct packed {
    logic [15:0] hsl;
    logic [31:0] rgba;
  } color_t;

  color_t colors_due[$];
  string  field_names[4] = '{"red", "green", "blue", "light_alpha"};
  int     mismatches = 0;
  int     due_count = 0;
  int     good_count = 0;

  assign fail_count      = mismatches;
  assign pending         = due_count;
  assign results_checked = good_count;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // One channel of the HSL ramp: wrap the hue, pick the segment, scale to a byte.
  function automatic logic [7:0] ramp_byte(input longint hue_t, input longint p,
                                           input longint q);
    longint span;
    longint level;
    longint scaled;
    span = q - p;
    if (hue_t > ONE_FX) hue_t -= ONE_FX;
    if (hue_t < 0) hue_t += ONE_FX;
    if (6 * hue_t < ONE_FX) begin
      level = p + ((span * 6 * hue_t) >>> phsl_pkg::FRAC_BITS);
    end else if (2 * hue_t < ONE_FX) begin
      level = q;
    end else if (3 * hue_t < 2 * ONE_FX) begin
      level = p + ((span * 6 * (TWO_THIRDS_FX - hue_t)) >>> phsl_pkg::FRAC_BITS);
    end else begin
      level = p;
    end
    if (level < 0) level = 0;
    scaled = (level * 255) >>> phsl_pkg::FRAC_BITS;
    if (scaled > 255) scaled = 255;
    return scaled[7:0];
  endfunction

  function automatic logic [31:0] hsl_to_rgba(input logic [15:0] word);
    longint hue_code;
    longint sat_code;
    longint light_code;
    longint hue_fx;
    longint sat_fx;
    longint light_fx;
    longint light_sat;
    longint q;
    longint p;
    longint alpha;
    hue_code   = longint'(word[15:10]);
    sat_code   = longint'(word[9:7]);
    light_code = longint'(word[6:0]);
    hue_fx     = (2 * hue_code + 1) <<< 17;
    sat_fx     = (2 * sat_code + 1) <<< 20;
    light_fx   = light_code <<< 17;
    light_sat  = (light_code * (2 * sat_code + 1)) <<< 13;
    // Dark colors take Q = L(1+S); bright ones take Q = L+S-LS.
    if (light_code < 64) begin
      q = light_fx + light_sat;
    end else begin
      q = light_fx + sat_fx - light_sat;
    end
    p = 2 * light_fx - q;
    alpha = light_code * 255 / 127;
    return {ramp_byte(hue_fx + THIRD_FX, p, q), ramp_byte(hue_fx, p, q),
            ramp_byte(hue_fx - THIRD_FX, p, q), alpha[7:0]};
  endfunction

  always @(posedge clk) begin
    color_t      want;
    logic [31:0] got;
    if (!rst) begin
      if (done) begin
        got = {red, green, blue, light_alpha};
        if (colors_due.size() == 0) begin
          report_mismatch($sformatf("result beat %08h with no color outstanding", got));
        end else begin
          want = colors_due.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[31-8*i -: 8] !== want.rgba[31-8*i -: 8]) begin
              report_mismatch($sformatf("input %04h %s got %0d expected %0d", want.hsl,
                                        field_names[i], got[31-8*i -: 8],
                                        want.rgba[31-8*i -: 8]));
            end
          end
          good_count++;
        end
      end
      if (start && !busy) begin
        colors_due.push_back('{hsl: packed_hsl, rgba: hsl_to_rgba(packed_hsl)});
      end
    end
    due_count = colors_due.size();
  end

endmodule

/* bench/tb_top.sv */
// Top of the packed_hsl_to_rgb testbench: clock, reset and input beats.
// Depends on packed_hsl_to_rgb, phsl_pkg and the phsl_checker module.
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_PER_PHASE = 630;
  localparam int DRAIN_CYCLES     = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] packed_hsl = 16'h0000;
  logic        busy;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  light_alpha;

  int fail_count;
  int pending;
  int results_checked;
  int beats_sent = 0;
  int sender_idle_pct = 35;
  int idle_rates[3] = '{35, 77, 0};

  always #5 clk = ~clk;

  packed_hsl_to_rgb u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .packed_hsl  (packed_hsl),
    .done        (done),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .light_alpha (light_alpha)
  );

  phsl_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .packed_hsl      (packed_hsl),
    .done            (done),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .light_alpha     (light_alpha),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  function automatic logic [15:0] hsl_word(input int hue, input int sat, input int light);
    return {6'(hue), 3'(sat), 7'(light)};
  endfunction

  // Called at a rising edge; returns at the edge that accepted the beat.
  // busy only moves at rising edges, so its value at the falling edge is
  // the one the next rising edge sees.
  task automatic send_color(input logic [15:0] color);
    logic held;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    packed_hsl <= color;
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
    beats_sent++;
  endtask

  initial begin
    logic [15:0] corners[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, the dark/bright lightness split and the hue segment edges,
    // including hues that wrap past one and below zero.
    corners = '{16'h0000, 16'hffff, hsl_word(0, 7, 63), hsl_word(0, 7, 64),
                hsl_word(63, 0, 63), hsl_word(63, 0, 64), hsl_word(63, 7, 127),
                hsl_word(0, 0, 127), hsl_word(10, 3, 1), hsl_word(11, 3, 126),
                hsl_word(31, 5, 40), hsl_word(32, 5, 90), hsl_word(42, 6, 70),
                hsl_word(43, 6, 20), hsl_word(21, 7, 64), hsl_word(53, 1, 100),
                hsl_word(32, 4, 0), hsl_word(5, 2, 127), 16'haaaa, 16'h5555};
    foreach (corners[i]) send_color(corners[i]);

    foreach (idle_rates[phase]) begin
      sender_idle_pct = idle_rates[phase];
      repeat (RANDOM_PER_PHASE) send_color(16'($urandom_range(0, 65535)));
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d colors: corner cases, then random words at sender idle rates",
             beats_sent);
    $display("of 35, 77 and 0 percent; %0d results compared, %0d mismatches.",
             results_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("FAIL");
    $finish;
  end

endmodule

/* packed_hsl_to_rgb.f */
rtl/phsl_pkg.sv
rtl/phsl_decode.sv
rtl/phsl_channel.sv
rtl/packed_hsl_to_rgb.sv
bench/phsl_checker.sv
bench/tb_top.sv
